// File: design/pfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer pool package
// Shared widths, parameter defaults, request codes and status codes of the
// partitioned frame buffer pool.
// ----------------------------------------------------------------------------
package pfb_pkg;

    // Fixed field widths of the request and result ports.
    localparam int IMG_W  = 29;
    localparam int CAM_W  = 2;
    localparam int SLOT_W = 4;
    localparam int DIM_W  = 16;
    localparam int OFS_W  = 32;

    // Parameter defaults.
    localparam int DEF_POOL_SLOTS   = 16;
    localparam int DEF_CAMERA_COUNT = 4;
    localparam int DEF_READER_LIMIT = 15;

    // Request actions.
    typedef enum logic [1:0] {
        ACT_CLAIM   = 2'd0,
        ACT_PUBLISH = 2'd1,
        ACT_ACQUIRE = 2'd2,
        ACT_RELEASE = 2'd3
    } t_action;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_BAD   = 2'd2
    } t_status;

endpackage

// File: design/partitioned_frame_buffer_pool_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned frame buffer pool core
// Reference-counted pool of frame slots split evenly among cameras: claim,
// publish, acquire of the latest frame, and release of a pinned frame.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken at a rising edge with start high and busy low. busy
//   stays high while the request is worked on; one result follows on the
//   o_ ports for exactly one cycle, marked by o_done. The receiver cannot
//   stall, and a new request may be started in the cycle o_done is high.
//   A claim examines 1 to POOL_SLOTS / CAMERA_COUNT slots of its slice; each
//   slot examined is read from the slot store and then checked, and the
//   offset comes from one registered multiply.
//   image_bytes is written through i_cfg_we / i_cfg_wdata while idle; the
//   user must keep to this, as the block itself does not enforce it.
//   Reset makes every slot free and untagged, clears all latest pointers
//   and sets image_bytes to 1; the store needs no clearing pass.
// ----------------------------------------------------------------------------
module partitioned_frame_buffer_pool_core
    import pfb_pkg::*;
#(
    parameter int POOL_SLOTS   = DEF_POOL_SLOTS,
    parameter int CAMERA_COUNT = DEF_CAMERA_COUNT,
    parameter int READER_LIMIT = DEF_READER_LIMIT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_action,
    input  logic [CAM_W-1:0]  i_camera,
    input  logic              i_any_camera,
    input  logic [SLOT_W-1:0] i_slot,
    input  logic [DIM_W-1:0]  i_frame_width_in,
    input  logic [DIM_W-1:0]  i_frame_height_in,
    input  logic              i_cfg_we,
    input  logic [IMG_W-1:0]  i_cfg_wdata,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_slot_out,
    output logic [OFS_W-1:0]  o_byte_offset,
    output logic [DIM_W-1:0]  o_frame_width_out,
    output logic [DIM_W-1:0]  o_frame_height_out,
    output logic [CAM_W-1:0]  o_frame_camera_out
);

    localparam int SW           = $clog2(POOL_SLOTS);
    localparam int SLICE        = POOL_SLOTS / CAMERA_COUNT;
    localparam int SLICE_D      = (SLICE == 0) ? 1 : SLICE;
    localparam int OW           = (SLICE_D > 1) ? $clog2(SLICE_D) : 1;
    localparam int CIW          = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1;
    localparam int CW           = $clog2(READER_LIMIT + 2);
    localparam int TAGW         = $clog2(CAMERA_COUNT + 1);
    localparam int EW           = CW + TAGW + 2 * DIM_W;
    localparam int SLOT_WRITING = READER_LIMIT + 1;
    localparam logic [EW-1:0] RESET_WORD = {CW'(0), TAGW'(CAMERA_COUNT), {2*DIM_W{1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_READ,
        S_CHECK,
        S_MUL,
        S_OUT
    } t_state;

    t_state                  r_state;
    t_action                 r_act;
    logic [CAM_W-1:0]        r_cam;
    logic                    r_any;
    logic [SLOT_W-1:0]       r_slot_in;
    logic [DIM_W-1:0]        r_w_in;
    logic [DIM_W-1:0]        r_h_in;
    logic [SW-1:0]           r_addr;
    logic [OW-1:0]           r_off;
    logic [OW-1:0]           r_cnt;
    t_status                 r_status;
    logic [DIM_W-1:0]        r_w_res;
    logic [DIM_W-1:0]        r_h_res;
    logic [CAM_W-1:0]        r_cam_res;
    logic [CAMERA_COUNT-1:0] r_lat_v;
    logic [SW-1:0]           r_lat_slot [CAMERA_COUNT];
    logic                    r_lat_any_v;
    logic [SW-1:0]           r_lat_any_slot;
    logic [IMG_W-1:0]        r_image_bytes;

    logic                   r_o_done;
    t_status                r_o_status;
    logic [SLOT_W-1:0]      r_o_slot;
    logic [OFS_W-1:0]       r_o_ofs;
    logic [DIM_W-1:0]       r_o_w;
    logic [DIM_W-1:0]       r_o_h;
    logic [CAM_W-1:0]       r_o_cam;

    logic                   cam_bad;
    logic                   slot_bad;
    logic [SW-1:0]          slot_idx;
    logic [CIW-1:0]         cam_idx;
    logic [SW-1:0]          slice_start;
    logic                   lat_v_c;
    logic [SW-1:0]          lat_slot_c;
    logic                   in_slice;
    logic [OW-1:0]          rel;
    logic [OW-1:0]          first_off;
    logic [OW-1:0]          off_next;
    logic                   scan_last;

    logic [EW-1:0]          rd_word;
    logic [CW-1:0]          rd_cnt;
    logic [TAGW-1:0]        rd_tag;
    logic [DIM_W-1:0]       rd_w;
    logic [DIM_W-1:0]       rd_h;
    logic                   chk_ok;
    t_status                chk_code;
    logic [EW-1:0]          chk_word;
    logic [EW-1:0]          pub_word;

    logic                   mem_rd_en;
    logic                   mem_wr_en;
    logic [SW-1:0]          mem_wr_addr;
    logic [EW-1:0]          mem_wr_data;
    logic [OFS_W-1:0]       mul_ofs;

    // Argument range checks and slice geometry of the latched request.
    assign cam_bad     = 32'(r_cam) >= CAMERA_COUNT;
    assign slot_bad    = 32'(r_slot_in) >= POOL_SLOTS;
    assign slot_idx    = SW'(r_slot_in);
    assign cam_idx     = CIW'(r_cam);
    assign slice_start = SW'(32'(r_cam) * SLICE);
    assign lat_v_c     = r_lat_v[cam_idx];
    assign lat_slot_c  = r_lat_slot[cam_idx];
    assign in_slice    = lat_v_c && (32'(lat_slot_c) >= 32'(slice_start))
                         && (32'(lat_slot_c) < 32'(slice_start) + SLICE);
    assign rel         = OW'(lat_slot_c - slice_start);

    // Claim scan starts after the slot the camera last published.
    always_comb begin
        first_off = '0;
        if (in_slice) begin
            first_off = (32'(rel) == SLICE_D - 1) ? '0 : OW'(rel + 1'b1);
        end
    end

    assign off_next  = (32'(r_off) == SLICE_D - 1) ? '0 : OW'(r_off + 1'b1);
    assign scan_last = (32'(r_cnt) == SLICE_D - 1);

    // Fields of the slot entry just read.
    assign rd_cnt = rd_word[EW-1 -: CW];
    assign rd_tag = rd_word[2*DIM_W +: TAGW];
    assign rd_w   = rd_word[DIM_W +: DIM_W];
    assign rd_h   = rd_word[DIM_W-1:0];

    assign pub_word = {CW'(0), TAGW'(r_cam), r_w_in, r_h_in};

    // Check of the read entry and its updated contents.
    always_comb begin
        chk_ok   = 1'b0;
        chk_code = ST_EMPTY;
        chk_word = rd_word;
        unique case (r_act)
            ACT_CLAIM: begin
                chk_ok   = (rd_cnt == '0);
                chk_word = {CW'(SLOT_WRITING), rd_tag, rd_w, rd_h};
            end
            ACT_ACQUIRE: begin
                chk_ok   = (r_any || (32'(rd_tag) == 32'(r_cam)))
                           && (32'(rd_cnt) < READER_LIMIT);
                chk_word = {CW'(rd_cnt + 1'b1), rd_tag, rd_w, rd_h};
            end
            ACT_RELEASE: begin
                chk_ok   = (rd_cnt != '0) && (32'(rd_cnt) <= READER_LIMIT);
                chk_code = ST_BAD;
                chk_word = {CW'(rd_cnt - 1'b1), rd_tag, rd_w, rd_h};
            end
            ACT_PUBLISH: begin
                chk_code = ST_BAD;
            end
            default: begin
                chk_code = ST_BAD;
            end
        endcase
    end

    // Slot store port control.
    assign mem_rd_en   = (r_state == S_READ);
    assign mem_wr_en   = ((r_state == S_DISPATCH) && (r_act == ACT_PUBLISH)
                          && !cam_bad && !slot_bad)
                         || ((r_state == S_CHECK) && chk_ok);
    assign mem_wr_addr = (r_state == S_DISPATCH) ? slot_idx : r_addr;
    assign mem_wr_data = (r_state == S_DISPATCH) ? pub_word : chk_word;

    pfb_slot_store #(
        .POOL_SLOTS (POOL_SLOTS),
        .EW         (EW),
        .RESET_WORD (RESET_WORD)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (r_addr),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data),
        .o_rd_data (rd_word)
    );

    pfb_offset_mul #(
        .SW (SW)
    ) u_mul (
        .i_clk         (i_clk),
        .i_en          (r_state == S_MUL),
        .i_slot        (r_addr),
        .i_image_bytes (r_image_bytes),
        .o_offset      (mul_ofs)
    );

    // Image size register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_bytes <= IMG_W'(1);
        end else if (i_cfg_we) begin
            r_image_bytes <= i_cfg_wdata;
        end
    end

    // Request sequencer with latest pointers and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_o_done    <= 1'b0;
            r_lat_v     <= '0;
            r_lat_any_v <= 1'b0;
        end else begin
            r_o_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_act     <= t_action'(i_action);
                        r_cam     <= i_camera;
                        r_any     <= i_any_camera;
                        r_slot_in <= i_slot;
                        r_w_in    <= i_frame_width_in;
                        r_h_in    <= i_frame_height_in;
                        r_w_res   <= '0;
                        r_h_res   <= '0;
                        r_cam_res <= '0;
                        r_state   <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    unique case (r_act)
                        ACT_CLAIM: begin
                            if (cam_bad) begin
                                r_status <= ST_BAD;
                                r_state  <= S_OUT;
                            end else if (SLICE == 0) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else begin
                                r_addr  <= slice_start + SW'(first_off);
                                r_off   <= first_off;
                                r_cnt   <= '0;
                                r_state <= S_READ;
                            end
                        end
                        ACT_PUBLISH: begin
                            if (cam_bad || slot_bad) begin
                                r_status <= ST_BAD;
                                r_state  <= S_OUT;
                            end else begin
                                r_lat_v[cam_idx]    <= 1'b1;
                                r_lat_slot[cam_idx] <= slot_idx;
                                r_lat_any_v         <= 1'b1;
                                r_lat_any_slot      <= slot_idx;
                                r_addr              <= slot_idx;
                                r_status            <= ST_OK;
                                r_state             <= S_MUL;
                            end
                        end
                        ACT_ACQUIRE: begin
                            if (r_any) begin
                                if (!r_lat_any_v) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_OUT;
                                end else begin
                                    r_addr  <= r_lat_any_slot;
                                    r_state <= S_READ;
                                end
                            end else if (cam_bad) begin
                                r_status <= ST_BAD;
                                r_state  <= S_OUT;
                            end else if (!in_slice) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_OUT;
                            end else begin
                                r_addr  <= lat_slot_c;
                                r_state <= S_READ;
                            end
                        end
                        ACT_RELEASE: begin
                            if (slot_bad) begin
                                r_status <= ST_BAD;
                                r_state  <= S_OUT;
                            end else begin
                                r_addr  <= slot_idx;
                                r_state <= S_READ;
                            end
                        end
                        default: begin
                            r_status <= ST_BAD;
                            r_state  <= S_OUT;
                        end
                    endcase
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (chk_ok) begin
                        r_status <= ST_OK;
                        if (r_act == ACT_ACQUIRE) begin
                            r_w_res   <= rd_w;
                            r_h_res   <= rd_h;
                            r_cam_res <= CAM_W'(rd_tag);
                        end
                        r_state <= S_MUL;
                    end else if ((r_act == ACT_CLAIM) && !scan_last) begin
                        // Step to the next slot of the slice, wrapping around.
                        r_cnt   <= OW'(r_cnt + 1'b1);
                        r_off   <= off_next;
                        r_addr  <= slice_start + SW'(off_next);
                        r_state <= S_READ;
                    end else begin
                        r_status <= chk_code;
                        r_state  <= S_OUT;
                    end
                end
                S_MUL: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_o_done   <= 1'b1;
                    r_o_status <= r_status;
                    if (r_status == ST_OK) begin
                        r_o_slot <= SLOT_W'(r_addr);
                        r_o_ofs  <= mul_ofs;
                        r_o_w    <= r_w_res;
                        r_o_h    <= r_h_res;
                        r_o_cam  <= r_cam_res;
                    end else begin
                        r_o_slot <= '0;
                        r_o_ofs  <= '0;
                        r_o_w    <= '0;
                        r_o_h    <= '0;
                        r_o_cam  <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy               = (r_state != S_IDLE);
    assign o_done             = r_o_done;
    assign o_status           = r_o_status;
    assign o_slot_out         = r_o_slot;
    assign o_byte_offset      = r_o_ofs;
    assign o_frame_width_out  = r_o_w;
    assign o_frame_height_out = r_o_h;
    assign o_frame_camera_out = r_o_cam;

    // A request only finishes by presenting its result.
    a_done_on_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_done)
        else $error("request finished without a result strobe");

    // Every slot check comes in the cycle after a store read.
    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(r_state) == S_READ)
        else $error("slot check without a preceding read");

    // A failed request carries no slot or offset.
    a_fail_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_slot_out == '0) && (o_byte_offset == '0))
        else $error("failed request returned slot fields");

endmodule

// File: design/pfb_slot_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer pool slot store
// One-read, one-write memory holding reader count, camera tag and frame size
// of every slot. A valid bit per slot makes an unwritten slot read as the
// reset word, so no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module pfb_slot_store
    import pfb_pkg::*;
#(
    parameter int              POOL_SLOTS = DEF_POOL_SLOTS,
    parameter int              EW         = 40,
    parameter logic [EW-1:0]   RESET_WORD = '0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [$clog2(POOL_SLOTS)-1:0] i_rd_addr,
    input  logic                          i_wr_en,
    input  logic [$clog2(POOL_SLOTS)-1:0] i_wr_addr,
    input  logic [EW-1:0]                 i_wr_data,
    output logic [EW-1:0]                 o_rd_data
);

    logic [EW-1:0]         r_mem [POOL_SLOTS];
    logic [POOL_SLOTS-1:0] r_valid;
    logic [EW-1:0]         r_rd_data;
    logic                  r_rd_valid;

    // Memory array write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Per-slot written flags, cleared at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // A slot never written reads as its reset contents.
    assign o_rd_data = r_rd_valid ? r_rd_data : RESET_WORD;

endmodule

// File: design/pfb_offset_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame buffer pool offset multiplier
// Registered product of slot number and image size, kept to 32 bits.
// ----------------------------------------------------------------------------
module pfb_offset_mul
    import pfb_pkg::*;
#(
    parameter int SW = 4
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [SW-1:0]    i_slot,
    input  logic [IMG_W-1:0] i_image_bytes,
    output logic [OFS_W-1:0] o_offset
);

    logic [SW+IMG_W-1:0] product;
    logic [OFS_W-1:0]    r_offset;

    // The product wraps to the low 32 bits.
    assign product = (SW + IMG_W)'(i_slot) * (SW + IMG_W)'(i_image_bytes);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_offset <= OFS_W'(product);
        end
    end

    assign o_offset = r_offset;

endmodule

// File: test/tb_partitioned_frame_buffer_pool_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Partitioned frame buffer pool core testbench
// Drives claim, publish, acquire and release requests through the start/busy
// handshake with random gaps. Each accepted request is run through a pool
// model kept here, and every o_done result is compared field by field with
// the oldest predicted one. A second copy of the pool state steers the random
// traffic into well-formed claim/publish/acquire/release sequences. The run
// steps through several image_bytes settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_partitioned_frame_buffer_pool_core
    import pfb_pkg::*;
();

    localparam int SLOTS          = DEF_POOL_SLOTS;
    localparam int CAMS           = DEF_CAMERA_COUNT;
    localparam int LIMIT          = DEF_READER_LIMIT;
    localparam int SLICE          = SLOTS / CAMS;
    localparam int WRITING        = LIMIT + 1;
    localparam int TAG_NONE       = CAMS;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 230;
    localparam int IDLE_PCT       = 22;
    localparam int CALM_PHASE     = 4;
    localparam int SETTLE_CYCLES  = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // One request as presented on the input ports.
    typedef struct packed {
        t_action            action;
        logic [CAM_W-1:0]   camera;
        logic               any_cam;
        logic [SLOT_W-1:0]  slot;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
    } t_pfb_req;

    // One result as seen on the output ports.
    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [OFS_W-1:0]   offset;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [CAM_W-1:0]   camera;
    } t_pfb_rsp;

    // Pool contents: reader counts, tags, frame sizes and latest pointers.
    typedef struct packed {
        logic [IMG_W-1:0]             img;
        logic [SLOTS-1:0][4:0]        rc;
        logic [SLOTS-1:0][2:0]        tag;
        logic [SLOTS-1:0][DIM_W-1:0]  fw;
        logic [SLOTS-1:0][DIM_W-1:0]  fh;
        logic [CAMS-1:0]              cam_valid;
        logic [CAMS-1:0][SLOT_W-1:0]  cam_slot;
        logic                         all_valid;
        logic [SLOT_W-1:0]            all_slot;
    } t_pool_state;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_pfb_req          cur_req = '0;
    logic              cfg_we    = 1'b0;
    logic [IMG_W-1:0]  cfg_wdata = '0;
    logic              o_done;
    logic [1:0]        o_status;
    logic [SLOT_W-1:0] o_slot_out;
    logic [OFS_W-1:0]  o_byte_offset;
    logic [DIM_W-1:0]  o_frame_width_out;
    logic [DIM_W-1:0]  o_frame_height_out;
    logic [CAM_W-1:0]  o_frame_camera_out;

    t_pfb_req    queued_requests[$];
    t_pfb_rsp    due_results[$];
    t_pool_state seen_pool;
    t_pool_state plan_pool;
    logic        gaps_on     = 1'b1;
    int          n_issued    = 0;
    int          n_fail      = 0;
    int          idle_cycles = 0;

    partitioned_frame_buffer_pool_core dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (cur_req.action),
        .i_camera           (cur_req.camera),
        .i_any_camera       (cur_req.any_cam),
        .i_slot             (cur_req.slot),
        .i_frame_width_in   (cur_req.width),
        .i_frame_height_in  (cur_req.height),
        .i_cfg_we           (cfg_we),
        .i_cfg_wdata        (cfg_wdata),
        .o_done             (o_done),
        .o_status           (o_status),
        .o_slot_out         (o_slot_out),
        .o_byte_offset      (o_byte_offset),
        .o_frame_width_out  (o_frame_width_out),
        .o_frame_height_out (o_frame_height_out),
        .o_frame_camera_out (o_frame_camera_out)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Start of a slot's data: low 32 bits of slot times image bytes.
    function automatic logic [OFS_W-1:0] slot_offset(input logic [SLOT_W-1:0] s,
                                                     input logic [IMG_W-1:0] img);
        logic [63:0] prod;
        prod = {{(64 - SLOT_W){1'b0}}, s} * {{(64 - IMG_W){1'b0}}, img};
        return prod[OFS_W-1:0];
    endfunction

    // Pool state right after reset.
    function automatic t_pool_state empty_pool();
        t_pool_state st;
        st = '0;
        st.img = 1;
        for (int i = 0; i < SLOTS; i++) st.tag[i] = 3'(TAG_NONE);
        return st;
    endfunction

    // Applies one request to a pool and works out its result. The field widths
    // cover exactly the camera and slot ranges, so range errors cannot occur.
    function automatic void serve_request(inout t_pool_state st, input t_pfb_req rq,
                                          output t_pfb_rsp rs);
        int               base;
        int               first;
        int               cand;
        logic             hit;
        logic [SLOT_W-1:0] s;
        rs = '0;
        case (rq.action)
            ACT_CLAIM: begin
                // Round-robin search of the slice, starting after the last frame.
                base  = int'(rq.camera) * SLICE;
                first = 0;
                if (st.cam_valid[rq.camera] && int'(st.cam_slot[rq.camera]) >= base &&
                    int'(st.cam_slot[rq.camera]) < base + SLICE) begin
                    first = (int'(st.cam_slot[rq.camera]) - base + 1) % SLICE;
                end
                hit = 1'b0;
                for (int i = 0; i < SLICE; i++) begin
                    cand = base + (first + i) % SLICE;
                    if (!hit && st.rc[cand] == 0) begin
                        hit        = 1'b1;
                        st.rc[cand] = 5'(WRITING);
                        rs.slot    = SLOT_W'(cand);
                        rs.offset  = slot_offset(SLOT_W'(cand), st.img);
                    end
                end
                if (!hit) rs.status = ST_EMPTY;
            end
            ACT_PUBLISH: begin
                st.tag[rq.slot]        = {1'b0, rq.camera};
                st.fw[rq.slot]         = rq.width;
                st.fh[rq.slot]         = rq.height;
                st.rc[rq.slot]         = '0;
                st.cam_valid[rq.camera] = 1'b1;
                st.cam_slot[rq.camera]  = rq.slot;
                st.all_valid           = 1'b1;
                st.all_slot            = rq.slot;
                rs.slot                = rq.slot;
                rs.offset              = slot_offset(rq.slot, st.img);
            end
            ACT_ACQUIRE: begin
                // The per-camera latest frame must sit in the slice and carry the tag.
                if (rq.any_cam) begin
                    s   = st.all_slot;
                    hit = st.all_valid;
                end else begin
                    s   = st.cam_slot[rq.camera];
                    hit = st.cam_valid[rq.camera] && int'(s) / SLICE == int'(rq.camera) &&
                          st.tag[s] == {1'b0, rq.camera};
                end
                if (hit && st.rc[s] < 5'(LIMIT)) begin
                    st.rc[s]  = st.rc[s] + 5'd1;
                    rs.slot   = s;
                    rs.offset = slot_offset(s, st.img);
                    rs.width  = st.fw[s];
                    rs.height = st.fh[s];
                    rs.camera = st.tag[s][CAM_W-1:0];
                end else begin
                    rs.status = ST_EMPTY;
                end
            end
            default: begin
                // Release of a free or being-written slot is refused.
                if (st.rc[rq.slot] == 0 || st.rc[rq.slot] > 5'(LIMIT)) begin
                    rs.status = ST_BAD;
                end else begin
                    st.rc[rq.slot] = st.rc[rq.slot] - 5'd1;
                    rs.slot        = rq.slot;
                    rs.offset      = slot_offset(rq.slot, st.img);
                end
            end
        endcase
    endfunction

    // Request driver: holds start until accepted, predicts at acceptance.
    always @(posedge i_clk) begin : drive_requests
        t_pfb_rsp want;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                serve_request(seen_pool, cur_req, want);
                due_results.push_back(want);
            end
            if (start && busy) begin
                // Request still waiting; keep it on the ports.
            end else if (queued_requests.size() != 0 &&
                         !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
                cur_req <= queued_requests.pop_front();
                start   <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            n_fail++;
        end
    endtask

    // Result monitor: every o_done cycle is matched with the oldest prediction.
    always @(posedge i_clk) begin : check_results
        t_pfb_rsp want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                $error("result with no request outstanding, status %0d", o_status);
                n_fail++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("slot_out", 32'(want.slot), 32'(o_slot_out));
                check_field("byte_offset", want.offset, o_byte_offset);
                check_field("frame_width_out", 32'(want.width), 32'(o_frame_width_out));
                check_field("frame_height_out", 32'(want.height), 32'(o_frame_height_out));
                check_field("frame_camera_out", 32'(want.camera), 32'(o_frame_camera_out));
            end
        end
    end

    // Watchdog on cycles in which neither a request nor a result is taken.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[partitioned_frame_buffer_pool_core] ERROR");
                $finish;
            end
        end
    end

    // Queues one request and runs it on the planning copy of the pool.
    task automatic issue(input t_action act, input logic [CAM_W-1:0] cam,
                         input logic any_cam, input logic [SLOT_W-1:0] s,
                         input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                         output t_pfb_rsp planned);
        t_pfb_req rq;
        rq.action  = act;
        rq.camera  = cam;
        rq.any_cam = any_cam;
        rq.slot    = s;
        rq.width   = w;
        rq.height  = h;
        serve_request(plan_pool, rq, planned);
        queued_requests.push_back(rq);
        n_issued++;
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return DIM_W'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        do @(negedge i_clk);
        while (queued_requests.size() != 0 || due_results.size() != 0 || start);
    endtask

    task automatic set_image_bytes(input logic [IMG_W-1:0] v);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        seen_pool.img = v;
        plan_pool.img = v;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // Directed requests: empty pool, being-written slots, tag and slice
    // misses, publish over readers and an exhausted slice.
    task automatic run_directed();
        t_pfb_rsp got;
        issue(ACT_ACQUIRE, 2'd0, 1'b1, 4'd0, '0, '0, got);
        issue(ACT_ACQUIRE, 2'd2, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_RELEASE, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_CLAIM, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_RELEASE, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_PUBLISH, 2'd0, 1'b0, 4'd0, '1, '0, got);
        issue(ACT_ACQUIRE, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_ACQUIRE, 2'd0, 1'b1, 4'd0, '0, '0, got);
        issue(ACT_RELEASE, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_CLAIM, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_PUBLISH, 2'd0, 1'b0, 4'd1, '0, '1, got);
        // Camera 1 retags slot 1, which sits outside its own slice.
        issue(ACT_PUBLISH, 2'd1, 1'b0, 4'd1, 16'd640, 16'd480, got);
        issue(ACT_ACQUIRE, 2'd0, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_ACQUIRE, 2'd1, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_ACQUIRE, 2'd3, 1'b1, 4'd15, '1, '1, got);
        issue(ACT_PUBLISH, 2'd3, 1'b0, 4'd15, '1, '1, got);
        issue(ACT_ACQUIRE, 2'd3, 1'b0, 4'd0, '0, '0, got);
        // A publish drops the readers of the slot it overwrites.
        issue(ACT_PUBLISH, 2'd3, 1'b0, 4'd15, 16'h1234, 16'h5678, got);
        issue(ACT_RELEASE, 2'd3, 1'b1, 4'd15, '1, '1, got);
        repeat (5) issue(ACT_CLAIM, 2'd2, 1'b0, 4'd0, '0, '0, got);
        issue(ACT_RELEASE, 2'd0, 1'b0, 4'd1, '0, '0, got);
    endtask

    // Random traffic, mostly well-formed sequences planned on the pool copy.
    task automatic run_random(input int goal);
        t_pfb_rsp          got;
        logic [SLOT_W-1:0] pins[$];
        logic [CAM_W-1:0]  cam;
        logic              any_cam;
        int                kind;
        int                base;
        while (n_issued < goal) begin
            kind    = $urandom_range(99);
            cam     = CAM_W'($urandom_range(CAMS - 1));
            any_cam = 1'($urandom_range(1));
            pins.delete();
            if (kind < 40) begin
                // Claim, publish, a few readers, most of them let go.
                issue(ACT_CLAIM, cam, any_cam, SLOT_W'($urandom), pick_dim(), pick_dim(), got);
                if (got.status == ST_OK) begin
                    issue(ACT_PUBLISH, cam, any_cam, got.slot, pick_dim(), pick_dim(), got);
                end
                repeat ($urandom_range(3)) begin
                    issue(ACT_ACQUIRE, cam, 1'($urandom_range(1)), SLOT_W'($urandom),
                          pick_dim(), pick_dim(), got);
                    if (got.status == ST_OK) pins.push_back(got.slot);
                end
                foreach (pins[j]) begin
                    if ($urandom_range(3) != 0) begin
                        issue(ACT_RELEASE, cam, any_cam, pins[j], pick_dim(), pick_dim(), got);
                    end
                end
            end else if (kind < 50) begin
                // Pile readers onto one frame up to and past the limit.
                repeat ($urandom_range(12, 17)) begin
                    issue(ACT_ACQUIRE, cam, any_cam, SLOT_W'($urandom), pick_dim(),
                          pick_dim(), got);
                    if (got.status == ST_OK) pins.push_back(got.slot);
                end
                foreach (pins[j]) begin
                    if ($urandom_range(7) != 0) begin
                        issue(ACT_RELEASE, cam, any_cam, pins[j], pick_dim(), pick_dim(), got);
                    end
                end
            end else if (kind < 65) begin
                // Let go of some pinned slot, if any is pinned.
                base = $urandom_range(SLOTS - 1);
                for (int i = 0; i < SLOTS; i++) begin
                    if (pins.size() == 0 && plan_pool.rc[(base + i) % SLOTS] != 0 &&
                        plan_pool.rc[(base + i) % SLOTS] <= 5'(LIMIT)) begin
                        pins.push_back(SLOT_W'((base + i) % SLOTS));
                    end
                end
                if (pins.size() != 0) begin
                    issue(ACT_RELEASE, cam, any_cam, pins[0], pick_dim(), pick_dim(), got);
                end
            end else if (kind < 80) begin
                // Burst of claims on one slice, most of them published in reverse order.
                repeat ($urandom_range(2, 5)) begin
                    issue(ACT_CLAIM, cam, any_cam, SLOT_W'($urandom), pick_dim(),
                          pick_dim(), got);
                    if (got.status == ST_OK) pins.push_back(got.slot);
                end
                while (pins.size() != 0) begin
                    if ($urandom_range(4) != 0) begin
                        issue(ACT_PUBLISH, cam, any_cam, pins[pins.size() - 1], pick_dim(),
                              pick_dim(), got);
                    end
                    void'(pins.pop_back());
                end
            end else begin
                // Anything at all.
                issue(t_action'($urandom_range(3)), cam, any_cam, SLOT_W'($urandom),
                      DIM_W'($urandom), DIM_W'($urandom), got);
            end
        end
    endtask

    // Reset, then the directed phase and random phases under several sizes.
    initial begin : stimulus
        logic [IMG_W-1:0] img_plan[PHASES];
        seen_pool = empty_pool();
        plan_pool = empty_pool();
        img_plan  = '{29'h1000_0000, 29'h1FFF_FFFF, 29'h0FFF_FFFF, 29'd1,
                      29'd0, 29'd0, 29'd0, 29'h1000_0000};
        for (int p = 4; p < 7; p++) img_plan[p] = IMG_W'($urandom_range(1, 29'h1000_0000));
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_image_bytes(29'd1);
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            gaps_on = (p != CALM_PHASE);
            set_image_bytes(img_plan[p]);
            run_random(n_issued + PHASE_ITEMS);
        end
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (n_fail == 0 && due_results.size() == 0) begin
            $display("[partitioned_frame_buffer_pool_core] OK");
        end else begin
            $display("[partitioned_frame_buffer_pool_core] ERROR");
        end
        $finish;
    end

endmodule
